[rtl/tkz_pkg.sv]
// Shared token codes, scan modes, character constants and classification functions.
package tkz_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_NUMBER  = 4'b0010,
    MODE_NAME    = 4'b0100,
    MODE_COMMENT = 4'b1000
  } scan_mode_e;

  localparam int TYPE_W = 5;
  localparam int HEAD_W = 40;
  localparam int HLEN_W = 3;
  localparam int NUM_KW = 8;

  localparam logic [HLEN_W-1:0] HLEN_MAX = 3'd6;

  localparam logic [TYPE_W-1:0] TT_LPAR    = 5'd0;
  localparam logic [TYPE_W-1:0] TT_RPAR    = 5'd1;
  localparam logic [TYPE_W-1:0] TT_LBRK    = 5'd2;
  localparam logic [TYPE_W-1:0] TT_RBRK    = 5'd3;
  localparam logic [TYPE_W-1:0] TT_EQUAL   = 5'd4;
  localparam logic [TYPE_W-1:0] TT_COMMA   = 5'd5;
  localparam logic [TYPE_W-1:0] TT_SEMI    = 5'd6;
  localparam logic [TYPE_W-1:0] TT_COLON   = 5'd7;
  localparam logic [TYPE_W-1:0] TT_USCORE  = 5'd8;
  localparam logic [TYPE_W-1:0] TT_NUM     = 5'd9;
  localparam logic [TYPE_W-1:0] TT_KW_BASE = 5'd10;
  localparam logic [TYPE_W-1:0] TT_IDENT   = 5'd18;
  localparam logic [TYPE_W-1:0] TT_EOF     = 5'd19;

  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_HASH       = 8'h23;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_SEMICOLON  = 8'h3B;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_LBRACKET   = 8'h5B;
  localparam logic [7:0] CH_RBRACKET   = 8'h5D;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DIGIT_LO   = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI   = 8'h39;
  localparam logic [7:0] CH_UPPER_LO   = 8'h41;
  localparam logic [7:0] CH_UPPER_HI   = 8'h5A;
  localparam logic [7:0] CH_LOWER_LO   = 8'h61;
  localparam logic [7:0] CH_LOWER_HI   = 8'h7A;

  // Keywords in order: chip, in, out, parts, end, wire, true, false.
  localparam logic [HEAD_W-1:0] KW_BITS [NUM_KW] = '{
    40'h0063686970, 40'h000000696E, 40'h00006F7574, 40'h7061727473,
    40'h0000656E64, 40'h0077697265, 40'h0074727565, 40'h66616C7365
  };
  localparam logic [HLEN_W-1:0] KW_LEN [NUM_KW] = '{
    3'd4, 3'd2, 3'd3, 3'd5, 3'd3, 3'd4, 3'd4, 3'd5
  };

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_DIGIT_LO) && (c <= CH_DIGIT_HI);
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= CH_LOWER_LO) && (c <= CH_LOWER_HI)) ||
           ((c >= CH_UPPER_LO) && (c <= CH_UPPER_HI));
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    logic p;
    unique case (c)
      CH_LPAREN, CH_RPAREN, CH_LBRACKET, CH_RBRACKET, CH_EQUAL,
      CH_COMMA, CH_SEMICOLON, CH_COLON, CH_UNDERSCORE: p = 1'b1;
      default: p = 1'b0;
    endcase
    return p;
  endfunction

  function automatic logic [TYPE_W-1:0] punct_type(logic [7:0] c);
    logic [TYPE_W-1:0] t;
    unique case (c)
      CH_LPAREN:     t = TT_LPAR;
      CH_RPAREN:     t = TT_RPAR;
      CH_LBRACKET:   t = TT_LBRK;
      CH_RBRACKET:   t = TT_RBRK;
      CH_EQUAL:      t = TT_EQUAL;
      CH_COMMA:      t = TT_COMMA;
      CH_SEMICOLON:  t = TT_SEMI;
      CH_COLON:      t = TT_COLON;
      default:       t = TT_USCORE;
    endcase
    return t;
  endfunction

  function automatic logic [TYPE_W-1:0] name_type(logic [HEAD_W-1:0] head,
                                                  logic [HLEN_W-1:0] hlen);
    logic [TYPE_W-1:0] t;
    t = TT_IDENT;
    for (int i = NUM_KW - 1; i >= 0; i--) begin
      if ((hlen == KW_LEN[i]) && (head == KW_BITS[i])) begin
        t = TT_KW_BASE + TYPE_W'(i);
      end
    end
    return t;
  endfunction

endpackage

[rtl/tkz_stream_if.sv]
// Valid/ready stream interfaces for source bytes and for tokens.
interface tkz_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_source;

  modport source (output valid, output char_byte, output end_of_source, input ready);
  modport sink (input valid, input char_byte, input end_of_source, output ready);
endinterface

interface tkz_out_if #(
  parameter int LINE_WIDTH = 16,
  parameter int POS_WIDTH  = 20
);
  logic                  valid;
  logic                  ready;
  logic [4:0]            token_type;
  logic [LINE_WIDTH-1:0] line_number;
  logic [POS_WIDTH-1:0]  start_pos;
  logic [POS_WIDTH-1:0]  token_length;
  logic                  last_of_run;

  modport source (output valid, output token_type, output line_number, output start_pos,
                  output token_length, output last_of_run, input ready);
  modport sink (input valid, input token_type, input line_number, input start_pos,
                input token_length, input last_of_run, output ready);
endinterface

[rtl/tkz_front.sv]
// Front end: accepts source bytes, tracks scan state and builds token pairs.
module tkz_front #(
  parameter int LINE_WIDTH = 16,
  parameter int POS_WIDTH  = 20,
  parameter int ENTRY_W    = 11 + LINE_WIDTH + 4 * POS_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  tkz_in_if.sink             in_i,
  input  logic               full_i,
  output logic               push_o,
  output logic [ENTRY_W-1:0] entry_o
);

  typedef struct packed {
    logic                              two;
    logic [tkz_pkg::TYPE_W-1:0]        type0;
    logic [LINE_WIDTH-1:0]             line;
    logic [POS_WIDTH-1:0]              start0;
    logic [POS_WIDTH-1:0]              len0;
    logic [tkz_pkg::TYPE_W-1:0]        type1;
    logic [POS_WIDTH-1:0]              start1;
    logic [POS_WIDTH-1:0]              len1;
  } entry_t;

  tkz_pkg::scan_mode_e               mode_q, mode_d;
  logic [LINE_WIDTH-1:0]             line_q, line_d;
  logic [POS_WIDTH-1:0]              pos_q, pos_d;
  logic [POS_WIDTH-1:0]              start_q, start_d;
  logic [tkz_pkg::HEAD_W-1:0]        head_q, head_d;
  logic [tkz_pkg::HLEN_W-1:0]        hlen_q, hlen_d;

  logic [7:0]                 c;
  logic                       accept;
  logic                       restart;
  logic                       line_inc;
  logic                       fl_valid;
  logic [tkz_pkg::TYPE_W-1:0] fl_type;
  logic                       sec_valid;
  logic [tkz_pkg::TYPE_W-1:0] sec_type;
  logic [POS_WIDTH-1:0]       sec_len;
  logic                       pending;
  entry_t                     entry;

  assign c         = in_i.char_byte;
  assign in_i.ready = !full_i;
  assign accept    = in_i.valid && !full_i;
  assign pending   = (mode_q == tkz_pkg::MODE_NUMBER) || (mode_q == tkz_pkg::MODE_NAME);

  always_comb begin
    mode_d    = mode_q;
    line_d    = line_q;
    pos_d     = pos_q;
    start_d   = start_q;
    head_d    = head_q;
    hlen_d    = hlen_q;
    restart   = 1'b0;
    line_inc  = 1'b0;
    fl_valid  = 1'b0;
    sec_valid = 1'b0;
    sec_type  = tkz_pkg::TT_EOF;
    sec_len   = '0;
    if (in_i.end_of_source) begin
      fl_valid  = pending;
      sec_valid = 1'b1;
      mode_d    = tkz_pkg::MODE_IDLE;
    end else begin
      if (pos_q != '1) begin
        pos_d = pos_q + POS_WIDTH'(1);
      end
      unique case (mode_q)
        tkz_pkg::MODE_COMMENT: begin
          if (c == tkz_pkg::CH_NEWLINE) begin
            mode_d   = tkz_pkg::MODE_IDLE;
            line_inc = 1'b1;
          end
        end
        tkz_pkg::MODE_NUMBER: begin
          restart = !tkz_pkg::is_digit(c);
        end
        tkz_pkg::MODE_NAME: begin
          if (tkz_pkg::is_letter(c) || tkz_pkg::is_digit(c) ||
              (c == tkz_pkg::CH_UNDERSCORE)) begin
            if (hlen_q < tkz_pkg::HLEN_MAX) begin
              head_d = {head_q[tkz_pkg::HEAD_W-9:0], c};
              hlen_d = hlen_q + tkz_pkg::HLEN_W'(1);
            end
          end else begin
            restart = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase
      if (restart) begin
        fl_valid = pending;
        mode_d   = tkz_pkg::MODE_IDLE;
        if (c == tkz_pkg::CH_NEWLINE) begin
          line_inc = 1'b1;
        end else if (c == tkz_pkg::CH_HASH) begin
          mode_d = tkz_pkg::MODE_COMMENT;
        end else if (tkz_pkg::is_punct(c)) begin
          sec_valid = 1'b1;
          sec_type  = tkz_pkg::punct_type(c);
          sec_len   = POS_WIDTH'(1);
        end else if (tkz_pkg::is_digit(c)) begin
          mode_d  = tkz_pkg::MODE_NUMBER;
          start_d = pos_q;
        end else if (tkz_pkg::is_letter(c)) begin
          mode_d  = tkz_pkg::MODE_NAME;
          start_d = pos_q;
          head_d  = {{(tkz_pkg::HEAD_W-8){1'b0}}, c};
          hlen_d  = tkz_pkg::HLEN_W'(1);
        end
      end
    end
    if (line_inc && (line_q != '1)) begin
      line_d = line_q + LINE_WIDTH'(1);
    end
  end

  assign fl_type = (mode_q == tkz_pkg::MODE_NUMBER) ? tkz_pkg::TT_NUM
                                                    : tkz_pkg::name_type(head_q, hlen_q);

  always_comb begin
    entry.line   = line_q;
    entry.type1  = sec_type;
    entry.start1 = pos_q;
    entry.len1   = sec_len;
    if (fl_valid) begin
      entry.two    = sec_valid;
      entry.type0  = fl_type;
      entry.start0 = start_q;
      entry.len0   = pos_q - start_q;
    end else begin
      entry.two    = 1'b0;
      entry.type0  = sec_type;
      entry.start0 = pos_q;
      entry.len0   = sec_len;
    end
  end

  assign push_o  = accept && (fl_valid || sec_valid);
  assign entry_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= tkz_pkg::MODE_IDLE;
      line_q  <= LINE_WIDTH'(1);
      pos_q   <= '0;
      start_q <= '0;
      head_q  <= '0;
      hlen_q  <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      head_q  <= head_d;
      hlen_q  <= hlen_d;
    end
  end

endmodule

[rtl/tkz_fifo.sv]
// Small first-in first-out queue of token pairs between front and back end.
module tkz_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              avail_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d;
  logic [PTR_W-1:0]  rd_q, rd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign avail_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && avail_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/tkz_back.sv]
// Back end: splits queued token pairs into single tokens in an output register.
module tkz_back #(
  parameter int LINE_WIDTH = 16,
  parameter int POS_WIDTH  = 20,
  parameter int ENTRY_W    = 11 + LINE_WIDTH + 4 * POS_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               avail_i,
  input  logic [ENTRY_W-1:0] entry_i,
  output logic               pop_o,
  tkz_out_if.source          out_o
);

  typedef struct packed {
    logic                              two;
    logic [tkz_pkg::TYPE_W-1:0]        type0;
    logic [LINE_WIDTH-1:0]             line;
    logic [POS_WIDTH-1:0]              start0;
    logic [POS_WIDTH-1:0]              len0;
    logic [tkz_pkg::TYPE_W-1:0]        type1;
    logic [POS_WIDTH-1:0]              start1;
    logic [POS_WIDTH-1:0]              len1;
  } entry_t;

  entry_t                     entry;
  logic                       load;
  logic                       ov_q;
  logic                       pend_q;
  logic [tkz_pkg::TYPE_W-1:0] type_q;
  logic [LINE_WIDTH-1:0]      line_q;
  logic [POS_WIDTH-1:0]       start_q;
  logic [POS_WIDTH-1:0]       len_q;
  logic                       last_q;
  logic [tkz_pkg::TYPE_W-1:0] ptype_q;
  logic [POS_WIDTH-1:0]       pstart_q;
  logic [POS_WIDTH-1:0]       plen_q;

  assign entry = entry_i;
  assign load  = !ov_q || out_o.ready;
  assign pop_o = load && !pend_q && avail_i;

  assign out_o.valid        = ov_q;
  assign out_o.token_type   = type_q;
  assign out_o.line_number  = line_q;
  assign out_o.start_pos    = start_q;
  assign out_o.token_length = len_q;
  assign out_o.last_of_run  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      pend_q <= 1'b0;
    end else if (load) begin
      if (pend_q) begin
        ov_q   <= 1'b1;
        pend_q <= 1'b0;
      end else begin
        ov_q   <= avail_i;
        pend_q <= avail_i && entry.two;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_q) begin
        type_q  <= ptype_q;
        start_q <= pstart_q;
        len_q   <= plen_q;
        last_q  <= 1'b1;
      end else if (avail_i) begin
        type_q   <= entry.type0;
        line_q   <= entry.line;
        start_q  <= entry.start0;
        len_q    <= entry.len0;
        last_q   <= !entry.two;
        ptype_q  <= entry.type1;
        pstart_q <= entry.start1;
        plen_q   <= entry.len1;
      end
    end
  end

endmodule

[rtl/hdl_source_tokenizer_unit.sv]
// Top level of the source tokenizer: front end, token queue and back end.
//
//   Channel     Dir  Payload                                              Accepted when
//   in_chan_i   in   char_byte, end_of_source                             valid && ready
//   out_chan_o  out  token_type, line_number, start_pos, token_length,    valid && ready
//                    last_of_run
//
// The front end takes one byte request per cycle while the four-entry token queue has room.
// The back end splits a byte's two tokens into two output tokens, sent one after the other.
// Results pass through a queue entry and then the output register before they appear.
// Reset clears the scan state, empties the queue and drops the output valid; no clearing pass is needed.
// Output stalls fill the queue and only then hold off new input requests.
module hdl_source_tokenizer_unit #(
  parameter int LINE_WIDTH = 16,
  parameter int POS_WIDTH  = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tkz_in_if.sink     in_chan_i,
  tkz_out_if.source  out_chan_o
);

  localparam int ENTRY_W    = 11 + LINE_WIDTH + 4 * POS_WIDTH;
  localparam int FIFO_DEPTH = 4;

  logic               push;
  logic               full;
  logic               pop;
  logic               avail;
  logic [ENTRY_W-1:0] wr_entry;
  logic [ENTRY_W-1:0] rd_entry;

  tkz_front #(
    .LINE_WIDTH (LINE_WIDTH),
    .POS_WIDTH  (POS_WIDTH),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_chan_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (wr_entry)
  );

  tkz_fifo #(
    .DATA_W (ENTRY_W),
    .DEPTH  (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (wr_entry),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .data_o  (rd_entry)
  );

  tkz_back #(
    .LINE_WIDTH (LINE_WIDTH),
    .POS_WIDTH  (POS_WIDTH),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .entry_i (rd_entry),
    .pop_o   (pop),
    .out_o   (out_chan_o)
  );

endmodule

[tb/sv/hdl_source_tokenizer_unit_tb.sv]
// Self-checking testbench for the source tokenizer: directed table and random source text.
`timescale 1ns / 100ps

module hdl_source_tokenizer_unit_tb;

  localparam int LINE_W = 16;
  localparam int POS_W  = 20;
  localparam int HOLD_CYCLES = 250;
  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam logic [POS_W-1:0]  POS_MAX  = '1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] PUNCT_CH [9] = '{
    tkz_pkg::CH_LPAREN, tkz_pkg::CH_RPAREN, tkz_pkg::CH_LBRACKET, tkz_pkg::CH_RBRACKET,
    tkz_pkg::CH_EQUAL, tkz_pkg::CH_COMMA, tkz_pkg::CH_SEMICOLON, tkz_pkg::CH_COLON,
    tkz_pkg::CH_UNDERSCORE
  };

  typedef struct packed {
    logic [tkz_pkg::TYPE_W-1:0] ttype;
    logic [LINE_W-1:0]          line_no;
    logic [POS_W-1:0]           start;
    logic [POS_W-1:0]           len;
    logic                       last;
  } token_t;

  typedef struct {
    logic [7:0] c;
    logic       eos;
    bit         fixed;
    int         n;
    token_t     tok;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tkz_in_if in_if ();
  tkz_out_if #(.LINE_WIDTH(LINE_W), .POS_WIDTH(POS_W)) out_if ();

  hdl_source_tokenizer_unit #(
    .LINE_WIDTH(LINE_W),
    .POS_WIDTH (POS_W)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_chan_i (in_if),
    .out_chan_o(out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  string kw_text [tkz_pkg::NUM_KW] = '{"chip", "in", "out", "parts", "end", "wire", "true",
                                       "false"};

  tkz_pkg::scan_mode_e        lx_mode  = tkz_pkg::MODE_IDLE;
  logic [LINE_W-1:0]          lx_line  = LINE_W'(1);
  logic [POS_W-1:0]           lx_pos   = '0;
  logic [POS_W-1:0]           lx_start = '0;
  logic [tkz_pkg::HEAD_W-1:0] lx_head  = '0;
  logic [tkz_pkg::HLEN_W-1:0] lx_hlen  = '0;

  token_t lex_out[$];
  token_t pending_tokens[$];
  stim_row_t dir_rows[$];

  int err_cnt   = 0;
  int req_count = 0;
  bit hold_req  = 1'b0;

  function automatic bit is_dec(logic [7:0] c);
    return c inside {[tkz_pkg::CH_DIGIT_LO:tkz_pkg::CH_DIGIT_HI]};
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c inside {[tkz_pkg::CH_LOWER_LO:tkz_pkg::CH_LOWER_HI]}) ||
           (c inside {[tkz_pkg::CH_UPPER_LO:tkz_pkg::CH_UPPER_HI]});
  endfunction

  function automatic bit punct_of(logic [7:0] c, output logic [tkz_pkg::TYPE_W-1:0] ty);
    bit hit;
    hit = 1'b1;
    case (c)
      tkz_pkg::CH_LPAREN:     ty = tkz_pkg::TT_LPAR;
      tkz_pkg::CH_RPAREN:     ty = tkz_pkg::TT_RPAR;
      tkz_pkg::CH_LBRACKET:   ty = tkz_pkg::TT_LBRK;
      tkz_pkg::CH_RBRACKET:   ty = tkz_pkg::TT_RBRK;
      tkz_pkg::CH_EQUAL:      ty = tkz_pkg::TT_EQUAL;
      tkz_pkg::CH_COMMA:      ty = tkz_pkg::TT_COMMA;
      tkz_pkg::CH_SEMICOLON:  ty = tkz_pkg::TT_SEMI;
      tkz_pkg::CH_COLON:      ty = tkz_pkg::TT_COLON;
      tkz_pkg::CH_UNDERSCORE: ty = tkz_pkg::TT_USCORE;
      default: begin
        ty = tkz_pkg::TT_IDENT;
        hit = 1'b0;
      end
    endcase
    return hit;
  endfunction

  function automatic void emit_token(logic [tkz_pkg::TYPE_W-1:0] ty, logic [POS_W-1:0] st,
                                     logic [POS_W-1:0] ln);
    token_t t;
    t.ttype   = ty;
    t.line_no = lx_line;
    t.start   = st;
    t.len     = ln;
    t.last    = 1'b0;
    lex_out.push_back(t);
  endfunction

  function automatic logic [tkz_pkg::TYPE_W-1:0] keyword_or_name();
    logic [tkz_pkg::TYPE_W-1:0] ty;
    ty = tkz_pkg::TT_IDENT;
    for (int i = 0; i < tkz_pkg::NUM_KW; i++) begin
      if ((lx_hlen == tkz_pkg::KW_LEN[i]) && (lx_head == tkz_pkg::KW_BITS[i])) begin
        ty = tkz_pkg::TT_KW_BASE + tkz_pkg::TYPE_W'(i);
        break;
      end
    end
    return ty;
  endfunction

  function automatic void flush_pending();
    if (lx_mode == tkz_pkg::MODE_NUMBER) begin
      emit_token(tkz_pkg::TT_NUM, lx_start, lx_pos - lx_start);
    end else if (lx_mode == tkz_pkg::MODE_NAME) begin
      emit_token(keyword_or_name(), lx_start, lx_pos - lx_start);
    end
    lx_mode = tkz_pkg::MODE_IDLE;
  endfunction

  function automatic void idle_char(logic [7:0] c);
    logic [tkz_pkg::TYPE_W-1:0] ty;
    if (c == tkz_pkg::CH_NEWLINE) begin
      if (lx_line != LINE_MAX) lx_line++;
    end else if (c == tkz_pkg::CH_HASH) begin
      lx_mode = tkz_pkg::MODE_COMMENT;
    end else if (punct_of(c, ty)) begin
      emit_token(ty, lx_pos, POS_W'(1));
    end else if (is_dec(c)) begin
      lx_mode  = tkz_pkg::MODE_NUMBER;
      lx_start = lx_pos;
    end else if (is_alpha(c)) begin
      lx_mode  = tkz_pkg::MODE_NAME;
      lx_start = lx_pos;
      lx_head  = tkz_pkg::HEAD_W'(c);
      lx_hlen  = tkz_pkg::HLEN_W'(1);
    end
  endfunction

  function automatic void predict_tokens(logic [7:0] c, logic eos);
    lex_out.delete();
    if (eos) begin
      flush_pending();
      emit_token(tkz_pkg::TT_EOF, lx_pos, '0);
    end else begin
      if (lx_mode == tkz_pkg::MODE_COMMENT) begin
        if (c == tkz_pkg::CH_NEWLINE) begin
          lx_mode = tkz_pkg::MODE_IDLE;
          idle_char(c);
        end
      end else if ((lx_mode == tkz_pkg::MODE_NUMBER) && is_dec(c)) begin
        // The number goes on.
      end else if ((lx_mode == tkz_pkg::MODE_NAME) &&
                   (is_alpha(c) || is_dec(c) || (c == tkz_pkg::CH_UNDERSCORE))) begin
        if (lx_hlen < tkz_pkg::HLEN_MAX) begin
          lx_head = {lx_head[tkz_pkg::HEAD_W-9:0], c};
          lx_hlen++;
        end
      end else begin
        flush_pending();
        idle_char(c);
      end
      if (lx_pos != POS_MAX) lx_pos++;
    end
    if (lex_out.size() > 0) lex_out[lex_out.size()-1].last = 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1)) begin
      return 8'($urandom_range(tkz_pkg::CH_LOWER_LO, tkz_pkg::CH_LOWER_HI));
    end
    return 8'($urandom_range(tkz_pkg::CH_UPPER_LO, tkz_pkg::CH_UPPER_HI));
  endfunction

  function automatic logic [7:0] name_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return rand_letter();
    if (r < 9) return 8'($urandom_range(tkz_pkg::CH_DIGIT_LO, tkz_pkg::CH_DIGIT_HI));
    return tkz_pkg::CH_UNDERSCORE;
  endfunction

  // One byte request; the expected tokens are queued once the request is taken.
  task automatic send_item(input logic [7:0] c, input logic eos, input bit steady = 1'b0,
                           input bit fixed = 1'b0, input int nfix = 0,
                           input token_t tfix = '0);
    int gap;
    in_if.valid         <= 1'b1;
    in_if.char_byte     <= c;
    in_if.end_of_source <= eos;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_tokens(c, eos);
    if (fixed) begin
      if (nfix > 0) pending_tokens.push_back(tfix);
    end else begin
      foreach (lex_out[k]) pending_tokens.push_back(lex_out[k]);
    end
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_fragment();
    logic [7:0] frag[$];
    logic [7:0] b;
    string kw;
    int r, n;
    bit steady;
    steady  = ($urandom_range(0, 9) == 0);
    r = $urandom_range(0, 99);
    if (r < 15) begin
      kw = kw_text[$urandom_range(0, tkz_pkg::NUM_KW - 1)];
      n = kw.len();
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      for (int i = 0; i < n; i++) frag.push_back(kw[i]);
      if ($urandom_range(0, 4) == 0) frag.push_back(name_char());
    end else if (r < 35) begin
      frag.push_back(rand_letter());
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
      repeat (n) frag.push_back(name_char());
    end else if (r < 48) begin
      repeat ($urandom_range(1, 6)) begin
        frag.push_back(8'($urandom_range(tkz_pkg::CH_DIGIT_LO, tkz_pkg::CH_DIGIT_HI)));
      end
    end else if (r < 68) begin
      frag.push_back(PUNCT_CH[$urandom_range(0, 8)]);
    end else if (r < 78) begin
      repeat ($urandom_range(1, 3)) begin
        n = $urandom_range(0, 2);
        frag.push_back((n == 0) ? CH_SPACE : (n == 1) ? CH_TAB : CH_CR);
      end
    end else if (r < 85) begin
      frag.push_back(tkz_pkg::CH_NEWLINE);
    end else if (r < 90) begin
      frag.push_back(tkz_pkg::CH_HASH);
      repeat ($urandom_range(0, 6)) begin
        b = 8'($urandom_range(0, 255));
        frag.push_back((b == tkz_pkg::CH_NEWLINE) ? tkz_pkg::CH_HASH : b);
      end
      frag.push_back(tkz_pkg::CH_NEWLINE);
    end else if (r < 98) begin
      frag.push_back(8'($urandom_range(0, 255)));
    end
    if (r >= 98) begin
      send_item(8'($urandom_range(0, 255)), 1'b1, steady);
      req_count++;
    end else begin
      foreach (frag[i]) send_item(frag[i], 1'b0, steady);
      req_count += frag.size();
    end
  endtask

  function automatic void check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    token_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected token: expected none, actual type %0d line %0d",
                 $time, out_if.token_type, out_if.line_number);
        $display("%0t: unexpected token: actual start %0d len %0d",
                 $time, out_if.start_pos, out_if.token_length);
        err_cnt++;
      end else begin
        want = pending_tokens.pop_front();
        check_field("token_type", 32'(want.ttype), 32'(out_if.token_type));
        check_field("line_number", 32'(want.line_no), 32'(out_if.line_number));
        check_field("start_pos", 32'(want.start), 32'(out_if.start_pos));
        check_field("token_length", 32'(want.len), 32'(out_if.token_length));
        check_field("last_of_run", 32'(want.last), 32'(out_if.last_of_run));
      end
    end
  end

  // The output side stalls at random; on request it holds off for a long stretch.
  initial begin
    int n;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8);
        repeat (n) @(posedge clk_i);
        n = pick_gap();
        if ((n > 0) && !hold_req) begin
          out_if.ready <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    string txt;
    in_if.valid         <= 1'b0;
    in_if.char_byte     <= 8'h00;
    in_if.end_of_source <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_rows.push_back(stim_row_t'{8'h00, 1'b1, 1'b1, 1,
                                   token_t'{tkz_pkg::TT_EOF, 16'd1, 20'd0, 20'd0, 1'b1}});
    dir_rows.push_back(stim_row_t'{8'h00, 1'b0, 1'b1, 0, '0});
    dir_rows.push_back(stim_row_t'{8'hFF, 1'b0, 1'b1, 0, '0});
    dir_rows.push_back(stim_row_t'{tkz_pkg::CH_LBRACKET, 1'b0, 1'b1, 1,
                                   token_t'{tkz_pkg::TT_LBRK, 16'd1, 20'd2, 20'd1, 1'b1}});
    dir_rows.push_back(stim_row_t'{tkz_pkg::CH_RBRACKET, 1'b0, 1'b1, 1,
                                   token_t'{tkz_pkg::TT_RBRK, 16'd1, 20'd3, 20'd1, 1'b1}});
    dir_rows.push_back(stim_row_t'{tkz_pkg::CH_COMMA, 1'b0, 1'b1, 1,
                                   token_t'{tkz_pkg::TT_COMMA, 16'd1, 20'd4, 20'd1, 1'b1}});
    dir_rows.push_back(stim_row_t'{tkz_pkg::CH_COLON, 1'b0, 1'b1, 1,
                                   token_t'{tkz_pkg::TT_COLON, 16'd1, 20'd5, 20'd1, 1'b1}});
    dir_rows.push_back(stim_row_t'{tkz_pkg::CH_UNDERSCORE, 1'b0, 1'b1, 1,
                                   token_t'{tkz_pkg::TT_USCORE, 16'd1, 20'd6, 20'd1, 1'b1}});
    txt = "in(7)=ab_9;#z\nend";
    for (int i = 0; i < txt.len(); i++) begin
      dir_rows.push_back(stim_row_t'{txt[i], 1'b0, 1'b0, 0, '0});
    end
    dir_rows.push_back(stim_row_t'{8'h00, 1'b1, 1'b0, 0, '0});

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].c, dir_rows[i].eos, 1'b0, dir_rows[i].fixed, dir_rows[i].n,
                dir_rows[i].tok);
    end
    drain();

    while (req_count < 400) send_fragment();
    // Long output stall while requests keep coming, so the token queue fills.
    hold_req = 1'b1;
    while (hold_req) send_fragment();
    while (req_count < 830) send_fragment();
    drain();

    send_item(8'h00, 1'b1);
    drain();

    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
